/* rtl/swmt_pkg.sv */
// ----------------------------------------------------------------------------
// swmt_pkg
// Constants, command and status types for the sliding window median block.
// ----------------------------------------------------------------------------
package swmt_pkg;

    localparam int WINDOW_SIZE = 100;
    localparam int CLASS_COUNT = 32;

    localparam int CLS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int TO_W      = 33;
    localparam int CLS_IDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CNT_W     = $clog2(WINDOW_SIZE + 1);
    localparam int ADDR_W    = $clog2(CLASS_COUNT * WINDOW_SIZE);
    localparam int MEM_DEPTH = CLASS_COUNT * WINDOW_SIZE;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_UPD  = 3'd1;
    localparam logic [ST_W-1:0] S_RDI  = 3'd2;
    localparam logic [ST_W-1:0] S_CAP  = 3'd3;
    localparam logic [ST_W-1:0] S_SCAN = 3'd4;
    localparam logic [ST_W-1:0] S_CHK  = 3'd5;
    localparam logic [ST_W-1:0] S_FIN  = 3'd6;

    typedef struct packed {
        logic capture;
        logic update;
        logic rd_cand;
        logic cap_cand;
        logic scan;
        logic next_cand;
        logic set_zero;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic scan_done;
        logic found;
        logic last_cand;
        logic out_busy;
    } t_status;

endpackage

/* rtl/swmt_if.sv */
// ----------------------------------------------------------------------------
// swmt_in_if / swmt_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface swmt_in_if
    import swmt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CLS_W-1:0]  class_id;
    logic [DATA_W-1:0] sample;

    modport source (output valid, class_id, sample, input ready);
    modport sink   (input valid, class_id, sample, output ready);
endinterface

interface swmt_out_if
    import swmt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] median;
    logic [TO_W-1:0]   timeout;

    modport source (output valid, median, timeout, input ready);
    modport sink   (input valid, median, timeout, output ready);
endinterface

/* rtl/swmt_ctrl.sv */
// ----------------------------------------------------------------------------
// swmt_ctrl
// Sequencer: update, then rank test of each candidate against the window.
// ----------------------------------------------------------------------------
module swmt_ctrl
    import swmt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (i_status.bad) begin
                    o_cmd.set_zero = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                o_cmd.rd_cand = 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_cand = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.found) begin
                    n_state = S_FIN;
                end else if (i_status.last_cand) begin
                    o_cmd.set_zero = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.next_cand = 1'b1;
                    n_state = S_RDI;
                end
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/swmt_dp.sv */
// ----------------------------------------------------------------------------
// swmt_dp
// Window memory, per-class fill and ring pointers, rank counters, output reg.
// ----------------------------------------------------------------------------
module swmt_dp
    import swmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [CLS_W-1:0]  i_class_id,
    input  logic [DATA_W-1:0] i_sample,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_median,
    output logic [TO_W-1:0]   o_timeout
);

    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [CNT_W-1:0]  r_fill [CLASS_COUNT];
    logic [CNT_W-1:0]  r_old [CLASS_COUNT];

    logic [CLS_W-1:0]  r_cls;
    logic [DATA_W-1:0] r_smp;
    logic [ADDR_W-1:0] r_base;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_cand;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_below;
    logic [CNT_W-1:0]  r_upto;
    logic [DATA_W-1:0] r_med;
    logic [TO_W-1:0]   r_to;
    logic              r_ovld;

    logic [CLS_IDX_W-1:0] cidx;
    logic [CNT_W-1:0]     fill;
    logic [CNT_W-1:0]     old;
    logic                 full;
    logic [CNT_W-1:0]     slot;
    logic [CNT_W-1:0]     n_n;
    logic [CNT_W-1:0]     k;
    logic [CNT_W:0]       i_inc;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_en;

    assign cidx = r_cls[CLS_IDX_W-1:0];
    assign fill = r_fill[cidx];
    assign old  = r_old[cidx];
    assign full = (fill == CNT_W'(WINDOW_SIZE));
    assign slot = full ? old : fill;
    assign n_n  = full ? fill : fill + CNT_W'(1);
    assign k    = r_n >> 1;
    assign i_inc = {1'b0, r_i} + (CNT_W+1)'(1);

    // the scan starts at entry 0, fetched while the candidate is captured
    assign rd_en   = i_cmd.rd_cand || i_cmd.cap_cand || (i_cmd.scan && (r_j != r_n));
    assign rd_addr = r_base + (i_cmd.rd_cand  ? ADDR_W'(r_i) :
                               i_cmd.cap_cand ? '0 : ADDR_W'(r_j));

    assign o_status.bad       = ({1'b0, r_cls} >= (CLS_W+1)'(CLASS_COUNT));
    assign o_status.scan_done = (r_j == r_n);
    assign o_status.found     = (r_below <= k) && (k < r_upto);
    assign o_status.last_cand = (i_inc == {1'b0, r_n});
    assign o_status.out_busy  = r_ovld && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_base + ADDR_W'(slot)] <= r_smp;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_fill[c] <= '0;
                r_old[c]  <= '0;
            end
        end else if (i_cmd.update) begin
            r_fill[cidx] <= n_n;
            if (full) begin
                r_old[cidx] <= (old == CNT_W'(WINDOW_SIZE - 1)) ? '0 : old + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cls  <= i_class_id;
            r_smp  <= i_sample;
            r_base <= ADDR_W'(i_class_id) * ADDR_W'(WINDOW_SIZE);
        end
        if (i_cmd.update) begin
            r_n <= n_n;
            r_i <= '0;
        end
        if (i_cmd.next_cand) begin
            r_i <= i_inc[CNT_W-1:0];
        end
        if (i_cmd.cap_cand) begin
            r_cand  <= r_rdata;
            r_j     <= CNT_W'(1);
            r_below <= '0;
            r_upto  <= '0;
        end
        if (i_cmd.scan) begin
            if (r_rdata < r_cand) begin
                r_below <= r_below + CNT_W'(1);
            end
            if (r_rdata <= r_cand) begin
                r_upto <= r_upto + CNT_W'(1);
            end
            if (r_j != r_n) begin
                r_j <= r_j + CNT_W'(1);
            end
        end
        if (i_cmd.set_zero) begin
            r_cand <= '0;
        end
        if (i_cmd.finish) begin
            r_med <= r_cand;
            r_to  <= {1'b0, r_cand} + {2'b00, r_cand[DATA_W-1:1]};
        end
    end

    // the scan counts the item read in the previous cycle, so the final
    // compare happens in the cycle where r_j reaches r_n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_median    = r_med;
    assign o_timeout   = r_to;

endmodule

/* rtl/sliding_window_median_timeout_core.sv */
// Each item is ranked one candidate at a time against the n entries of its
//   class window, and ends at the first candidate found to be the median.
// Throughput: one item at a time; the rank passes over the single read port
//   of the window memory bound how soon the next item is taken.
// Reset: synchronous, active low; clears fill counts and ring pointers of
//   every class. The window memory itself is not cleared.
// ----------------------------------------------------------------------------
// sliding_window_median_timeout_core
// Per-class sliding window median with a 1.5x timeout.
// ----------------------------------------------------------------------------
module sliding_window_median_timeout_core
    import swmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    swmt_in_if.sink    i_in,
    swmt_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    swmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swmt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_class_id  (i_in.class_id),
        .i_sample    (i_in.sample),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_median    (o_out.median),
        .o_timeout   (o_out.timeout)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while busy");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_out.valid)
        else $error("finished item not presented");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !status.out_busy)
        else $error("result overwrote pending item");

endmodule
